// ----- sv/ile_pkg.sv -----
// Package for the indexed list engine: list depth, request and status codes,
// datapath command and status structs. No dependencies.
`default_nettype none

package ile_pkg;

  localparam int unsigned DEPTH = 64;

  localparam int unsigned REQ_W = 4;
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned CNT_W = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_GET        = 4'd6;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 4'd7;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 4'd8;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    KIND_INS,
    KIND_DEL,
    KIND_RD
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic load_req;   // latch incoming word
    logic load_dec;   // latch decoded index, status, kind
    logic rd_idx;     // read slot at target index
    logic rd_prev;    // read slot p-1
    logic rd_next;    // read slot p+1
    logic wr_shift;   // slot p <= read data
    logic p_dec;
    logic p_inc;
    logic wr_final;   // slot idx <= value, count up
    logic capture;    // result <= read data, p <= idx
    logic cnt_dec;
    logic publish;    // output register <= status, result, count
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  err;
    kind_e kind;
    logic  p_gt_idx;
    logic  p_next_lt_cnt;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/indexed_list_engine_top.sv -----
// Indexed list engine: an ordered list of up to ile_pkg::DEPTH (64) signed
// 32-bit values held in a single-port-write, registered-read slot memory. Each
// request word (push/pop at either end, insert/delete/get at an index, peek at
// either end) gives exactly one result word: status, value and the entry count
// after the request. Insert and delete move the slots above the index one
// place, one slot at a time through the memory's one read and one write
// port, so the time per word depends on the request and on how many slots
// lie above the index. The input is ready again in the cycle in which the
// result is offered. One finished result can wait in the output register
// while the next word is worked; the input stalls only when that next
// result is also finished before the first has been taken.
// Slot memory needs no clearing after reset: only slots below the count are
// read. Depends on ile_pkg, ile_ctrl and ile_datapath.
`default_nettype none

module indexed_list_engine_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [ile_pkg::REQ_W-1:0]        req_type_i,
  input  wire logic [ile_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [ile_pkg::VAL_W-1:0] item_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [ile_pkg::ST_W-1:0]              status_o,
  output logic signed [ile_pkg::VAL_W-1:0]      result_value_o,
  output logic [ile_pkg::CNT_W-1:0]             entry_count_o
);

  ile_pkg::cmd_t  cmd;
  ile_pkg::stat_t stat;

  // Sequencer
  ile_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage, pointer, result and output registers
  ile_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

`default_nettype wire

// ----- sv/ile_datapath.sv -----
// Datapath of the indexed list engine: request registers, slot memory,
// shift pointer, entry count, result and output registers. Uses ile_pkg.
`default_nettype none

module ile_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ile_pkg::cmd_t                    cmd_i,
  output ile_pkg::stat_t                        stat_o,
  input  wire logic [ile_pkg::REQ_W-1:0]        req_type_i,
  input  wire logic [ile_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [ile_pkg::VAL_W-1:0] item_value_i,
  output logic [ile_pkg::ST_W-1:0]              status_o,
  output logic signed [ile_pkg::VAL_W-1:0]      result_value_o,
  output logic [ile_pkg::CNT_W-1:0]             entry_count_o
);

  localparam int unsigned AW    = $clog2(ile_pkg::DEPTH);
  localparam int unsigned CNTIW = $clog2(ile_pkg::DEPTH + 1);
  localparam int unsigned CMPW  = (CNTIW > ile_pkg::POS_W) ? CNTIW : ile_pkg::POS_W;

  logic [ile_pkg::REQ_W-1:0] req_q;
  logic [ile_pkg::POS_W-1:0] pos_q;
  logic [ile_pkg::VAL_W-1:0] val_q;
  logic [ile_pkg::VAL_W-1:0] res_q;
  logic [ile_pkg::VAL_W-1:0] rd_q;
  logic [ile_pkg::ST_W-1:0]  status_q;
  ile_pkg::kind_e            kind_q;
  logic [AW-1:0]             idx_q;
  logic [AW-1:0]             p_q;
  logic [CNTIW-1:0]          count_q;
  logic [ile_pkg::ST_W-1:0]  out_status_q;
  logic [ile_pkg::VAL_W-1:0] out_value_q;
  logic [ile_pkg::CNT_W-1:0] out_count_q;

  logic [ile_pkg::VAL_W-1:0] mem [ile_pkg::DEPTH];

  logic [CMPW-1:0]           cnt_ext, pos_ext, cnt_m1, dec_idx;
  logic                      full, empty;
  ile_pkg::kind_e            dec_kind;
  logic [ile_pkg::ST_W-1:0]  dec_st;
  logic [AW-1:0]             raddr, waddr;
  logic                      re, we;
  logic [ile_pkg::VAL_W-1:0] wdata;
  logic [CNTIW-1:0]          p_next;

  assign cnt_ext = CMPW'(count_q);
  assign pos_ext = CMPW'(pos_q);
  assign cnt_m1  = cnt_ext - CMPW'(1);
  assign full    = (cnt_ext == CMPW'(ile_pkg::DEPTH));
  assign empty   = (count_q == '0);

  always_comb begin
    dec_kind = ile_pkg::KIND_RD;
    dec_st   = ile_pkg::ST_RANGE;
    dec_idx  = '0;
    case (req_q)
      ile_pkg::REQ_PUSH_FRONT: begin
        dec_kind = ile_pkg::KIND_INS;
        dec_st   = full ? ile_pkg::ST_FULL : ile_pkg::ST_OK;
      end
      ile_pkg::REQ_PUSH_BACK: begin
        dec_kind = ile_pkg::KIND_INS;
        dec_st   = full ? ile_pkg::ST_FULL : ile_pkg::ST_OK;
        dec_idx  = cnt_ext;
      end
      ile_pkg::REQ_POP_FRONT: begin
        dec_kind = ile_pkg::KIND_DEL;
        dec_st   = empty ? ile_pkg::ST_RANGE : ile_pkg::ST_OK;
      end
      ile_pkg::REQ_POP_BACK: begin
        dec_kind = ile_pkg::KIND_DEL;
        dec_st   = empty ? ile_pkg::ST_RANGE : ile_pkg::ST_OK;
        dec_idx  = cnt_m1;
      end
      ile_pkg::REQ_INSERT: begin
        dec_kind = ile_pkg::KIND_INS;
        dec_st   = full ? ile_pkg::ST_FULL : ile_pkg::ST_OK;
        dec_idx  = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;  // past end: append
      end
      ile_pkg::REQ_DELETE: begin
        dec_kind = ile_pkg::KIND_DEL;
        dec_st   = (pos_ext >= cnt_ext) ? ile_pkg::ST_RANGE : ile_pkg::ST_OK;
        dec_idx  = pos_ext;
      end
      ile_pkg::REQ_GET: begin
        dec_st   = (pos_ext >= cnt_ext) ? ile_pkg::ST_RANGE : ile_pkg::ST_OK;
        dec_idx  = pos_ext;
      end
      ile_pkg::REQ_PEEK_FRONT: begin
        dec_st   = empty ? ile_pkg::ST_RANGE : ile_pkg::ST_OK;
      end
      ile_pkg::REQ_PEEK_BACK: begin
        dec_st   = empty ? ile_pkg::ST_RANGE : ile_pkg::ST_OK;
        dec_idx  = cnt_m1;
      end
      default: begin
        dec_st   = ile_pkg::ST_RANGE;
      end
    endcase
  end

  // Memory port control
  always_comb begin
    re    = cmd_i.rd_idx | cmd_i.rd_prev | cmd_i.rd_next;
    raddr = idx_q;
    if (cmd_i.rd_prev) begin
      raddr = p_q - AW'(1);
    end else if (cmd_i.rd_next) begin
      raddr = p_q + AW'(1);
    end
    we    = cmd_i.wr_shift | cmd_i.wr_final;
    waddr = cmd_i.wr_final ? idx_q : p_q;
    wdata = cmd_i.wr_final ? val_q : rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Request and result words
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    if (cmd_i.load_dec) begin
      status_q <= dec_st;
      kind_q   <= dec_kind;
      idx_q    <= dec_idx[AW-1:0];
      res_q    <= '0;
    end else if (cmd_i.capture) begin
      res_q    <= rd_q;
    end
  end

  // Output register: holds a finished word while the next one is worked
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_q <= status_q;
      out_value_q  <= res_q;
      out_count_q  <= cnt_ext[ile_pkg::CNT_W-1:0];
    end
  end

  // Shift pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_dec) begin
      p_q <= cnt_ext[AW-1:0];
    end else if (cmd_i.capture) begin
      p_q <= idx_q;
    end else if (cmd_i.p_dec) begin
      p_q <= p_q - AW'(1);
    end else if (cmd_i.p_inc) begin
      p_q <= p_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.wr_final) begin
      count_q <= count_q + CNTIW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CNTIW'(1);
    end
  end

  assign p_next = CNTIW'(p_q) + CNTIW'(1);

  assign stat_o.err           = (status_q != ile_pkg::ST_OK);
  assign stat_o.kind          = kind_q;
  assign stat_o.p_gt_idx      = (p_q > idx_q);
  assign stat_o.p_next_lt_cnt = (p_next < count_q);

  assign status_o       = out_status_q;
  assign result_value_o = out_value_q;
  assign entry_count_o  = out_count_q;

endmodule

`default_nettype wire

// ----- sv/ile_ctrl.sv -----
// Controller of the indexed list engine: sequences decode, memory shifts
// and result hand-off. Uses ile_pkg.
`default_nettype none

module ile_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire ile_pkg::stat_t stat_i,
  output ile_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_ROUTE    = 4'd2;
  localparam logic [3:0] S_INS_LOOP = 4'd3;
  localparam logic [3:0] S_INS_MOVE = 4'd4;
  localparam logic [3:0] S_FETCH    = 4'd5;
  localparam logic [3:0] S_CAPT     = 4'd6;
  localparam logic [3:0] S_DEL_LOOP = 4'd7;
  localparam logic [3:0] S_DEL_MOVE = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;  // taken at this edge
    case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.load_dec = 1'b1;
        state_d        = S_ROUTE;
      end
      S_ROUTE: begin
        if (stat_i.err) begin
          state_d = S_DONE;
        end else if (stat_i.kind == ile_pkg::KIND_INS) begin
          state_d = S_INS_LOOP;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_INS_LOOP: begin
        if (stat_i.p_gt_idx) begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_MOVE;
        end else begin
          cmd_o.wr_final = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_INS_MOVE: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.p_dec    = 1'b1;
        state_d        = S_INS_LOOP;
      end
      S_FETCH: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = S_CAPT;
      end
      S_CAPT: begin
        cmd_o.capture = 1'b1;
        state_d = (stat_i.kind == ile_pkg::KIND_RD) ? S_DONE : S_DEL_LOOP;
      end
      S_DEL_LOOP: begin
        if (stat_i.p_next_lt_cnt) begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_DEL_MOVE;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DEL_MOVE: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.p_inc    = 1'b1;
        state_d        = S_DEL_LOOP;
      end
      S_DONE: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
